// ----- design/deq_pkg.sv -----
package deq_pkg;

    localparam int DATA_W        = 32;
    localparam int DEPTH_DEFAULT = 16;

    // Value returned by a pop on an empty queue
    localparam logic signed [DATA_W-1:0] POP_EMPTY_VALUE = -32'sd1;

    typedef enum logic [1:0] {
        MODE_PUSH_REAR  = 2'd0,
        MODE_PUSH_FRONT = 2'd1,
        MODE_POP_REAR   = 2'd2,
        MODE_POP_FRONT  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    // What every cell of a chain does at each clock edge
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_SHIFT_UP   = 2'd1,
        CELL_SHIFT_DOWN = 2'd2,
        CELL_LOAD_EDGE  = 2'd3
    } cell_op_t;

endpackage

// ----- design/deq_cell.sv -----
module deq_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  logic                                clk,
    input  deq_pkg::cell_op_t                   op,
    input  logic [CNT_W-1:0]                    count,
    input  logic signed [deq_pkg::DATA_W-1:0]   value,
    input  logic signed [deq_pkg::DATA_W-1:0]   lower,
    input  logic signed [deq_pkg::DATA_W-1:0]   upper,
    output logic signed [deq_pkg::DATA_W-1:0]   data
);
    import deq_pkg::*;

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    // Take from a neighbor, or load the item when this cell sits just past the last one
    always_comb
    begin
        data_next = data_reg;
        case (op)
            CELL_HOLD:       data_next = data_reg;
            CELL_SHIFT_UP:   data_next = lower;
            CELL_SHIFT_DOWN: data_next = upper;
            CELL_LOAD_EDGE:
            begin
                if (count == CNT_W'(INDEX))
                begin
                    data_next = value;
                end
            end
            default:         data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ----- design/deq_chain.sv -----
module deq_chain #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                                clk,
    input  deq_pkg::cell_op_t                   op,
    input  logic [CNT_W-1:0]                    count,
    input  logic signed [deq_pkg::DATA_W-1:0]   value,
    output logic signed [deq_pkg::DATA_W-1:0]   head
);
    import deq_pkg::*;

    logic signed [DATA_W-1:0] cell_data [DEPTH];

    // Row of cells; cell 0 is the open end of this chain
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] lower_data;
        logic signed [DATA_W-1:0] upper_data;

        if (i == 0)
        begin : g_first
            assign lower_data = value;
        end
        else
        begin : g_mid_lo
            assign lower_data = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign upper_data = cell_data[i];
        end
        else
        begin : g_mid_hi
            assign upper_data = cell_data[i+1];
        end

        deq_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk   (clk),
            .op    (op),
            .count (count),
            .value (value),
            .lower (lower_data),
            .upper (upper_data),
            .data  (cell_data[i])
        );
    end

    assign head = cell_data[0];

endmodule

// ----- design/double_ended_queue_unit.sv -----
// Channel   Ports                                 Direction  Handshake
// command   start, busy, mode, push_value         in         start && !busy
// result    done, pop_value, status, fill_count   out        done, one cycle
//
// One item per cycle; busy stays low. The result shows in the cycle after the
// item is taken, from the output registers behind the two cell chains.
// Each chain keeps every element, one in front order and one in rear order,
// so each pop reads cell 0 of one chain and every cell acts on local data.
// Reset clears the count and the result strobe; cell contents need none.
// The receiver cannot stall: a result is shown once and then replaced.
module double_ended_queue_unit #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        start,
    output logic                                        busy,
    input  logic [1:0]                                  mode,
    input  logic signed [deq_pkg::DATA_W-1:0]           push_value,
    output logic                                        done,
    output logic signed [deq_pkg::DATA_W-1:0]           pop_value,
    output logic [1:0]                                  status,
    output logic [$clog2(DEPTH+1)-1:0]                  fill_count
);
    import deq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    logic                     accept;
    mode_t                    op_mode;
    logic                     is_full;
    logic                     is_empty;
    cell_op_t                 front_op;
    cell_op_t                 rear_op;
    logic signed [DATA_W-1:0] front_head;
    logic signed [DATA_W-1:0] rear_head;

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     done_reg;
    logic                     done_next;
    logic signed [DATA_W-1:0] pop_value_reg;
    logic signed [DATA_W-1:0] pop_value_next;
    status_t                  status_reg;
    status_t                  status_next;

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign op_mode  = mode_t'(mode);
    assign is_full  = (count_reg == FULL_COUNT);
    assign is_empty = (count_reg == '0);

    // Decode the item into chain operations and the result
    always_comb
    begin
        front_op       = CELL_HOLD;
        rear_op        = CELL_HOLD;
        count_next     = count_reg;
        done_next      = accept;
        pop_value_next = pop_value_reg;
        status_next    = status_reg;
        if (accept)
        begin
            pop_value_next = '0;
            status_next    = ST_OK;
            case (op_mode)
                MODE_PUSH_REAR:
                begin
                    if (is_full)
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        rear_op    = CELL_SHIFT_UP;
                        front_op   = CELL_LOAD_EDGE;
                        count_next = count_reg + 1'b1;
                    end
                end
                MODE_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        front_op   = CELL_SHIFT_UP;
                        rear_op    = CELL_LOAD_EDGE;
                        count_next = count_reg + 1'b1;
                    end
                end
                MODE_POP_REAR:
                begin
                    if (is_empty)
                    begin
                        status_next    = ST_UNDERFLOW;
                        pop_value_next = POP_EMPTY_VALUE;
                    end
                    else
                    begin
                        rear_op        = CELL_SHIFT_DOWN;
                        pop_value_next = rear_head;
                        count_next     = count_reg - 1'b1;
                    end
                end
                MODE_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        status_next    = ST_UNDERFLOW;
                        pop_value_next = POP_EMPTY_VALUE;
                    end
                    else
                    begin
                        front_op       = CELL_SHIFT_DOWN;
                        pop_value_next = front_head;
                        count_next     = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    // Hold the count and the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        pop_value_reg <= pop_value_next;
        status_reg    <= status_next;
    end

    // Front-ordered chain: cell 0 holds the front element
    deq_chain #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_front_chain (
        .clk   (clk),
        .op    (front_op),
        .count (count_reg),
        .value (push_value),
        .head  (front_head)
    );

    // Rear-ordered chain: cell 0 holds the rear element
    deq_chain #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_rear_chain (
        .clk   (clk),
        .op    (rear_op),
        .count (count_reg),
        .value (push_value),
        .head  (rear_head)
    );

    assign done       = done_reg;
    assign pop_value  = pop_value_reg;
    assign status     = status_reg;
    assign fill_count = count_reg;

    // One result for each item, in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("result missing after accepted item");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done)
        else $error("result without accepted item");

    // Refused push only on a full queue
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_reg == ST_OVERFLOW) |-> (count_reg == FULL_COUNT))
        else $error("overflow reported while not full");

    // Empty pop gives minus one and leaves the queue empty
    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_reg == ST_UNDERFLOW) |->
            (count_reg == '0 && pop_value_reg == POP_EMPTY_VALUE))
        else $error("underflow result inconsistent");

    // An accepted push grows the count by one
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_full &&
            (op_mode == MODE_PUSH_REAR || op_mode == MODE_PUSH_FRONT)) |=>
            (count_reg == $past(count_reg) + 1'b1))
        else $error("push did not grow count");

endmodule

// ----- test/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;

    localparam int DEPTH     = 16;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int NUM_RAND  = 1150;
    localparam int PHASE_LEN = 60;

    typedef struct {
        logic signed [DATA_W-1:0] pop_value;
        status_t                  status;
        logic [CNT_W-1:0]         fill_count;
    } deq_result_t;

    // Mirror of the deque contents and the results owed by the block
    class deque_scoreboard;
        logic signed [DATA_W-1:0] ring [DEPTH];
        int unsigned              front_idx;
        int unsigned              rear_idx;
        int unsigned              count;
        deq_result_t              owed_q [$];
        int                       errors;

        function new();
            front_idx = 0;
            rear_idx  = 0;
            count     = 0;
            errors    = 0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Apply one accepted item to the mirror and queue its result
        function void note_item(mode_t m, logic signed [DATA_W-1:0] v);
            deq_result_t r;
            r.pop_value = '0;
            r.status    = ST_OK;
            if (m == MODE_PUSH_REAR || m == MODE_PUSH_FRONT)
            begin
                if (count >= DEPTH)
                begin
                    r.status = ST_OVERFLOW;
                end
                else if (m == MODE_PUSH_REAR)
                begin
                    ring[rear_idx] = v;
                    rear_idx = (rear_idx + 1) % DEPTH;
                    count++;
                end
                else
                begin
                    front_idx = (front_idx + DEPTH - 1) % DEPTH;
                    ring[front_idx] = v;
                    count++;
                end
            end
            else
            begin
                if (count == 0)
                begin
                    r.status    = ST_UNDERFLOW;
                    r.pop_value = POP_EMPTY_VALUE;
                end
                else if (m == MODE_POP_REAR)
                begin
                    rear_idx = (rear_idx + DEPTH - 1) % DEPTH;
                    r.pop_value = ring[rear_idx];
                    count--;
                end
                else
                begin
                    r.pop_value = ring[front_idx];
                    front_idx = (front_idx + 1) % DEPTH;
                    count--;
                end
            end
            r.fill_count = CNT_W'(count);
            owed_q.push_back(r);
        endfunction

        // Compare one strobed result with the oldest owed result
        function void check_result(logic signed [DATA_W-1:0] pv, status_t st,
                                   logic [CNT_W-1:0] fc);
            deq_result_t e;
            if (owed_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result pop_value=%0d status=%s fill=%0d",
                             $realtime, pv, st.name(), fc);
                return;
            end
            e = owed_q.pop_front();
            if (pv !== e.pop_value || st !== e.status || fc !== e.fill_count)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: mismatch pop_value/status/fill exp %0d/%s/%0d got %0d/%s/%0d",
                             $realtime, e.pop_value, e.status.name(), e.fill_count,
                             pv, st.name(), fc);
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [1:0]               mode;
    logic signed [DATA_W-1:0] push_value;
    logic                     done;
    logic signed [DATA_W-1:0] pop_value;
    logic [1:0]               status;
    logic [CNT_W-1:0]         fill_count;

    deque_scoreboard sb = new();

    double_ended_queue_unit #(
        .DEPTH(DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .mode      (mode),
        .push_value(push_value),
        .done      (done),
        .pop_value (pop_value),
        .status    (status),
        .fill_count(fill_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Check strobed results first, then note the item taken at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(pop_value, status_t'(status), fill_count);
            if (start && !busy)
                sb.note_item(mode_t'(mode), push_value);
        end
    end

    // Present one item and hold it until the block takes it
    task automatic send_item(mode_t m, logic signed [DATA_W-1:0] v);
        start      <= 1'b1;
        mode       <= m;
        push_value <= v;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    // Drop start and put junk on the payload while idling
    task automatic idle_cycles(int n);
        start      <= 1'b0;
        mode       <= 2'($urandom);
        push_value <= $urandom;
        repeat (n) @(negedge clk);
    endtask

    // Pick a payload value, favoring the extremes now and then
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Underflow on both ends, extremes, emptying, fill to full and overflow
    task automatic run_directed();
        send_item(MODE_POP_REAR, 32'sh1234_5678);
        send_item(MODE_POP_FRONT, 32'sh0);
        send_item(MODE_PUSH_REAR, 32'sh7fff_ffff);
        send_item(MODE_PUSH_FRONT, 32'sh8000_0000);
        send_item(MODE_POP_REAR, -32'sd1);
        send_item(MODE_POP_FRONT, 32'sh0);
        for (int i = 0; i < DEPTH; i++)
        begin
            case (i % 4)
                0: send_item(MODE_PUSH_REAR, 32'sh8000_0000 + i);
                1: send_item(MODE_PUSH_FRONT, 32'sh7fff_ffff - i);
                2: send_item(MODE_PUSH_REAR, -32'sd1);
                default: send_item(MODE_PUSH_FRONT, 32'sh0 + i);
            endcase
        end
        send_item(MODE_PUSH_REAR, 32'sh5555_5555);
        send_item(MODE_PUSH_FRONT, 32'shaaaa_aaaa);
        send_item(MODE_POP_FRONT, 32'sh0);
        send_item(MODE_POP_REAR, 32'sh0);
    endtask

    // Random walk over fill levels, with push-heavy and pop-heavy phases
    task automatic run_random();
        int push_pct;
        bit quiet;
        mode_t m;
        push_pct = 50;
        for (int i = 0; i < NUM_RAND; i++)
        begin
            if (i % PHASE_LEN == 0)
            begin
                case ($urandom_range(3))
                    0:       push_pct = 10;
                    1:       push_pct = 50;
                    2:       push_pct = 75;
                    default: push_pct = 95;
                endcase
            end
            // Hold off until the block has answered everything
            if (i == 300 || i == 900)
            begin
                idle_cycles(1);
                while (sb.pending() != 0) @(negedge clk);
            end
            if ($urandom_range(99) < push_pct)
                m = $urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_REAR;
            else
                m = $urandom_range(1) ? MODE_POP_FRONT : MODE_POP_REAR;
            send_item(m, pick_value());
            quiet = (i >= 500 && i < 700);
            if (!quiet && $urandom_range(99) < 38)
            begin
                if ($urandom_range(9) == 0)
                    idle_cycles($urandom_range(4, 12));
                else
                    idle_cycles($urandom_range(1, 2));
            end
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        mode       = MODE_PUSH_REAR;
        push_value = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        idle_cycles(2);
        run_random();
        idle_cycles(1);

        // Drain owed results, then keep watching for strays before the verdict
        while (sb.pending() != 0) @(posedge clk);
        repeat (5) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #2ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
